// ===== rtl/pwcb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pulse width capture buffer package
// Shared constants, request codes, register indexes and channel payload types.
// ----------------------------------------------------------------------------
package pwcb_pkg;

  localparam int STORE_DEPTH = 512;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = 10;
  localparam int WIDTH_W     = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [COUNT_W-1:0] RESET_MIN_PULSES = COUNT_W'(64);

  typedef enum logic [1:0] {
    REQ_EDGE  = 2'd0,
    REQ_CHECK = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_type_e;

  localparam logic [CFG_IDX_W-1:0] CFG_ONE_WIDTH_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_WIDTH_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_WIDTH_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_WIDTH_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSES     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_ENABLE = 3'd6;

  typedef struct packed {
    req_type_e   req_type;
    logic        edge_level;
    logic [31:0] now_us;
    logic [31:0] now_ms;
    logic [8:0]  read_index;
  } req_t;

  typedef struct packed {
    logic               packet_ready;
    logic [COUNT_W-1:0] pulse_count;
    logic [WIDTH_W-1:0] read_data;
    logic               read_valid;
    logic               stored;
  } rsp_t;

endpackage
`default_nettype wire

// ===== rtl/pwcb_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pulse width capture buffer channels
// Valid/ready request and response channels with source and sink modports.
// ----------------------------------------------------------------------------
interface pwcb_req_if;
  logic          valid;
  logic          ready;
  pwcb_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pwcb_rsp_if;
  logic          valid;
  logic          ready;
  pwcb_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/pwcb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle; the read data register updates only on a read.
// ----------------------------------------------------------------------------
module pwcb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/pulse_width_capture_buffer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pulse width capture buffer core
// Measures high-pulse widths from edge requests, keeps in-window widths in a
// store, declares a packet ready after an idle timeout and reads entries back.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake     Carries
//   in_req   in   valid/ready   req_type, edge_level, now_us, now_ms, read_index
//   out_rsp  out  valid/ready   packet_ready, pulse_count, read_data,
//                               read_valid, stored
//   cfg      in   cfg_we_i      cfg_index_i, cfg_wdata_i (write only)
//
// Every request is resolved in the cycle it is accepted; one request may be
// accepted every clock unless the read stage is stalled. The response
// passes through the read stage, which holds the registered read of the
// single-port width store, and then the output register, so a new request
// is still accepted while one finished response waits to be taken.
// Reset clears all control state and the stored count; the store itself
// needs no clearing because only entries below the count are ever read.
// ----------------------------------------------------------------------------
module pulse_width_capture_buffer_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  pwcb_req_if.sink                            in_req,
  pwcb_rsp_if.source                          out_rsp,
  input  wire logic                           cfg_we_i,
  input  wire logic [pwcb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [pwcb_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  import pwcb_pkg::*;

  // Configuration registers.
  logic [31:0]        one_min_q, one_max_q, zero_min_q, zero_max_q;
  logic [15:0]        idle_timeout_q;
  logic [COUNT_W-1:0] min_pulses_q;
  logic               capture_en_q;

  // Block state.
  logic [COUNT_W-1:0] count_q, count_d;
  logic [31:0]        rise_time_q, rise_time_d;
  logic [31:0]        last_pulse_q, last_pulse_d;
  logic               ready_flag_q, ready_flag_d;

  // Read stage and output register.
  logic               s1_valid_q;
  logic               s1_ready_q, s1_rvalid_q, s1_stored_q;
  logic [COUNT_W-1:0] s1_count_q;
  logic               out_valid_q;
  rsp_t               out_q;

  logic               accept, s1_adv;
  logic [31:0]        width, idle_time, idx_ext, count_ext;
  logic               in_window, not_full, do_store, do_read;
  logic [WIDTH_W-1:0] ram_rdata;
  logic [ADDR_W-1:0]  ram_addr;
  req_t               req;

  assign req    = in_req.data;
  assign s1_adv = s1_valid_q && (!out_valid_q || out_rsp.ready);
  assign in_req.ready = !s1_valid_q || s1_adv;
  assign accept = in_req.valid && in_req.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_min_q      <= '0;
      one_max_q      <= '0;
      zero_min_q     <= '0;
      zero_max_q     <= '0;
      idle_timeout_q <= '0;
      min_pulses_q   <= RESET_MIN_PULSES;
      capture_en_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ONE_WIDTH_MIN:  one_min_q      <= cfg_wdata_i[31:0];
        CFG_ONE_WIDTH_MAX:  one_max_q      <= cfg_wdata_i[31:0];
        CFG_ZERO_WIDTH_MIN: zero_min_q     <= cfg_wdata_i[31:0];
        CFG_ZERO_WIDTH_MAX: zero_max_q     <= cfg_wdata_i[31:0];
        CFG_IDLE_TIMEOUT:   idle_timeout_q <= cfg_wdata_i[15:0];
        CFG_MIN_PULSES:     min_pulses_q   <= cfg_wdata_i[COUNT_W-1:0];
        CFG_CAPTURE_ENABLE: capture_en_q   <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // The width wraps modulo 2^32, as does the idle time.
  assign width     = req.now_us - rise_time_q;
  assign idle_time = req.now_ms - last_pulse_q;
  assign in_window = ((width >= one_min_q) && (width <= one_max_q)) ||
                     ((width >= zero_min_q) && (width <= zero_max_q));
  assign count_ext = 32'(count_q);
  assign idx_ext   = 32'(req.read_index);
  assign not_full  = count_ext < 32'(STORE_DEPTH);

  // A falling edge stores only while capturing, with no packet pending,
  // an in-window width and room left in the store.
  assign do_store = accept && (req.req_type == REQ_EDGE) && capture_en_q &&
                    !req.edge_level && !ready_flag_q && in_window && not_full;
  assign do_read  = accept && (req.req_type == REQ_READ) &&
                    (idx_ext < count_ext) && (idx_ext < 32'(STORE_DEPTH));

  always_comb begin
    count_d      = count_q;
    rise_time_d  = rise_time_q;
    last_pulse_d = last_pulse_q;
    ready_flag_d = ready_flag_q;
    if (accept) begin
      case (req.req_type)
        REQ_EDGE: begin
          if (capture_en_q && req.edge_level) begin
            rise_time_d = req.now_us;
          end
          if (do_store) begin
            count_d      = count_q + COUNT_W'(1);
            last_pulse_d = req.now_ms;
          end
        end
        REQ_CHECK: begin
          if ((count_q >= min_pulses_q) && (idle_time >= 32'(idle_timeout_q))) begin
            ready_flag_d = 1'b1;
          end
        end
        REQ_CLEAR: begin
          count_d      = '0;
          ready_flag_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      rise_time_q  <= '0;
      last_pulse_q <= '0;
      ready_flag_q <= 1'b0;
    end else begin
      count_q      <= count_d;
      rise_time_q  <= rise_time_d;
      last_pulse_q <= last_pulse_d;
      ready_flag_q <= ready_flag_d;
    end
  end

  // Writes go to the slot at the current count; reads to the requested index.
  assign ram_addr = do_store ? count_q[ADDR_W-1:0] : idx_ext[ADDR_W-1:0];

  pwcb_ram #(
    .WIDTH (WIDTH_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (do_store || do_read),
    .we_i    (do_store),
    .addr_i  (ram_addr),
    .wdata_i (width),
    .rdata_o (ram_rdata)
  );

  // The store is only accessed on an accepted request, so its read data
  // holds for as long as the read stage waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ready_q  <= ready_flag_d;
      s1_count_q  <= count_d;
      s1_rvalid_q <= do_read;
      s1_stored_q <= do_store;
    end
    if (s1_adv) begin
      out_q.packet_ready <= s1_ready_q;
      out_q.pulse_count  <= s1_count_q;
      out_q.read_data    <= s1_rvalid_q ? ram_rdata : '0;
      out_q.read_valid   <= s1_rvalid_q;
      out_q.stored       <= s1_stored_q;
    end
  end

  assign out_rsp.valid = out_valid_q;
  assign out_rsp.data  = out_q;

  // The read stage is never overwritten while its response is still held.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> !accept)
    else $error("read stage overwritten while stalled");

  // The count never passes the store depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(STORE_DEPTH))
    else $error("stored count beyond store depth");

  // A stored width advances the count by exactly one.
  a_store_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_store |=> (count_q == $past(count_q) + COUNT_W'(1)))
    else $error("store did not advance the count");

  // The packet flag is raised only by a check request.
  a_ready_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ready_flag_q && ready_flag_d) |-> (accept && (req.req_type == REQ_CHECK)))
    else $error("packet flag raised outside a check");

endmodule
`default_nettype wire

// ===== sim/pwcb_response_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse width capture buffer response checker
// Watches the request, response and register write ports, keeps its own copy
// of the capture store and compares every response field by field.
// ----------------------------------------------------------------------------
module pwcb_response_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  input  logic                            req_ready_i,
  input  pwcb_pkg::req_t                  req_data_i,
  input  logic                            rsp_valid_i,
  input  logic                            rsp_ready_i,
  input  pwcb_pkg::rsp_t                  rsp_data_i,
  input  logic                            cfg_we_i,
  input  logic [pwcb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pwcb_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned                     mismatch_count_o,
  output int unsigned                     owed_count_o
);

  import pwcb_pkg::*;

  localparam int unsigned MAX_REPORTED = 40;

  logic [31:0]        one_lo;
  logic [31:0]        one_hi;
  logic [31:0]        zero_lo;
  logic [31:0]        zero_hi;
  logic [15:0]        timeout_ms;
  logic [COUNT_W-1:0] min_count;
  logic               capture_on;

  logic [WIDTH_W-1:0] width_mem [STORE_DEPTH];
  logic [COUNT_W-1:0] held_count;
  logic [31:0]        rise_us;
  logic [31:0]        last_pulse_ms;
  logic               packet_flag;

  rsp_t        owed_rsp_q [$];
  int unsigned mismatches = 0;

  function automatic logic fits_window(input logic [31:0] width);
    return (width >= one_lo && width <= one_hi) || (width >= zero_lo && width <= zero_hi);
  endfunction

  // Applies one request to the local copy of the store and returns the
  // response that the block owes for it.
  function automatic rsp_t resolve_request(input req_t r);
    rsp_t        o;
    logic [31:0] width;
    logic [31:0] idle_ms;
    o = '0;
    case (r.req_type)
      REQ_EDGE: begin
        if (capture_on) begin
          if (r.edge_level) begin
            rise_us = r.now_us;
          end else begin
            width = r.now_us - rise_us;
            if (!packet_flag && fits_window(width) &&
                held_count < COUNT_W'(STORE_DEPTH)) begin
              width_mem[held_count[ADDR_W-1:0]] = width;
              held_count    = held_count + COUNT_W'(1);
              last_pulse_ms = r.now_ms;
              o.stored      = 1'b1;
            end
          end
        end
      end
      REQ_CHECK: begin
        idle_ms = r.now_ms - last_pulse_ms;
        if (!packet_flag && held_count >= min_count && idle_ms >= {16'd0, timeout_ms}) begin
          packet_flag = 1'b1;
        end
      end
      REQ_CLEAR: begin
        held_count  = '0;
        packet_flag = 1'b0;
      end
      default: begin
        if (COUNT_W'(r.read_index) < held_count) begin
          o.read_data  = width_mem[r.read_index];
          o.read_valid = 1'b1;
        end
      end
    endcase
    o.packet_ready = packet_flag;
    o.pulse_count  = held_count;
    return o;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      one_lo      = '0;
      one_hi      = '0;
      zero_lo     = '0;
      zero_hi     = '0;
      timeout_ms  = '0;
      min_count   = RESET_MIN_PULSES;
      capture_on  = 1'b1;
      held_count  = '0;
      rise_us     = '0;
      last_pulse_ms = '0;
      packet_flag = 1'b0;
      owed_rsp_q.delete();
      owed_count_o     <= 0;
      mismatch_count_o <= mismatches;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ONE_WIDTH_MIN:  one_lo     = cfg_wdata_i;
          CFG_ONE_WIDTH_MAX:  one_hi     = cfg_wdata_i;
          CFG_ZERO_WIDTH_MIN: zero_lo    = cfg_wdata_i;
          CFG_ZERO_WIDTH_MAX: zero_hi    = cfg_wdata_i;
          CFG_IDLE_TIMEOUT:   timeout_ms = cfg_wdata_i[15:0];
          CFG_MIN_PULSES:     min_count  = cfg_wdata_i[COUNT_W-1:0];
          CFG_CAPTURE_ENABLE: capture_on = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (req_valid_i && req_ready_i) begin
        owed_rsp_q.push_back(resolve_request(req_data_i));
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (owed_rsp_q.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want = owed_rsp_q.pop_front();
          compare_field("packet_ready", 32'(rsp_data_i.packet_ready), 32'(want.packet_ready));
          compare_field("pulse_count", 32'(rsp_data_i.pulse_count), 32'(want.pulse_count));
          compare_field("read_data", rsp_data_i.read_data, want.read_data);
          compare_field("read_valid", 32'(rsp_data_i.read_valid), 32'(want.read_valid));
          compare_field("stored", 32'(rsp_data_i.stored), 32'(want.stored));
        end
      end
      owed_count_o     <= owed_rsp_q.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// ===== sim/pulse_width_capture_buffer_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse width capture buffer core testbench
// Drives directed and random edge, check, clear and read requests through the
// core under varying back-pressure and register settings; a checker beside
// the core predicts and compares every response.
// ----------------------------------------------------------------------------
module pulse_width_capture_buffer_core_test;
  import pwcb_pkg::*;

  // Quiet cycles tolerated before the run is declared hung. The slowest
  // legitimate gap is the long receiver hold-off, well below this.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned LONG_HOLD      = 120;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned PHASE_ITEMS    = 270;
  // More falling edges than the store can hold, so that it overflows.
  localparam int unsigned FILL_EDGES     = 530;
  // An index past the register list; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pwcb_req_if req_ch ();
  pwcb_rsp_if rsp_ch ();

  int unsigned mismatch_count;
  int unsigned owed_count;

  // Idling percentages for the sender and the receiver, and the request for
  // one long receiver hold-off.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_wanted;

  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;

  // The stimulus keeps its own view of the windows and of the microsecond and
  // millisecond time of the pulse source, so that it can aim widths and checks at
  // the edges of the configured behaviour.
  logic [31:0] win_lo [2];
  logic [31:0] win_hi [2];
  logic [31:0] timeout_cfg;
  logic [31:0] us_now;
  logic [31:0] ms_now;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  pulse_width_capture_buffer_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_req      (req_ch),
    .out_rsp     (rsp_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  pwcb_response_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .req_valid_i      (req_ch.valid),
    .req_ready_i      (req_ch.ready),
    .req_data_i       (req_ch.data),
    .rsp_valid_i      (rsp_ch.valid),
    .rsp_ready_i      (rsp_ch.ready),
    .rsp_data_i       (rsp_ch.data),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatch_count),
    .owed_count_o     (owed_count)
  );

  // Any accepted request or response counts as progress. A run that stops
  // making progress for too long is a failure.
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Response side. Ready changes on the falling edge only. When the long
  // hold-off is requested it is counted out here, cycle by cycle, while the
  // sender keeps offering requests, so the core fills and stalls its input.
  initial begin : rsp_taker
    int unsigned hold_left;
    bit          hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_wanted && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one request and returns on the falling edge after it has been
  // accepted. Valid is left high so that back-to-back requests need no
  // gap; whoever stops sending lowers it.
  task automatic send_req(input req_type_e kind, input logic level, input logic [31:0] us,
                          input logic [31:0] ms, input logic [8:0] index);
    req_t r;
    r.req_type   = kind;
    r.edge_level = level;
    r.now_us     = us;
    r.now_ms     = ms;
    r.read_index = index;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    @(posedge clk);
    while (!req_ch.ready) begin
      @(posedge clk);
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  // Stops sending and waits until every response owed has been taken,
  // then lets the pipeline run empty.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (owed_count != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Registers are only written with the core idle. The unused index is
  // written with random data each time as well.
  task automatic configure(input logic [31:0] one_min, input logic [31:0] one_max,
                           input logic [31:0] zero_min, input logic [31:0] zero_max,
                           input logic [31:0] timeout, input logic [COUNT_W-1:0] min_pulses,
                           input logic capture);
    settle();
    win_lo[0]   = one_min;
    win_hi[0]   = one_max;
    win_lo[1]   = zero_min;
    win_hi[1]   = zero_max;
    timeout_cfg = {16'd0, timeout[15:0]};
    write_reg(CFG_ONE_WIDTH_MIN, one_min);
    write_reg(CFG_ONE_WIDTH_MAX, one_max);
    write_reg(CFG_ZERO_WIDTH_MIN, zero_min);
    write_reg(CFG_ZERO_WIDTH_MAX, zero_max);
    write_reg(CFG_IDLE_TIMEOUT, timeout);
    write_reg(CFG_MIN_PULSES, CFG_DATA_W'(min_pulses));
    write_reg(CFG_CAPTURE_ENABLE, CFG_DATA_W'(capture));
    write_reg(CFG_UNUSED_INDEX, $urandom());
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly widths inside one of the windows, with its bounds and the values
  // just outside them favoured; now and then any width at all.
  function automatic logic [31:0] pick_width();
    int unsigned w;
    int unsigned sel;
    w   = $urandom_range(1);
    sel = $urandom_range(9);
    if (win_lo[w] > win_hi[w] || sel == 9) begin
      return $urandom();
    end
    case (sel)
      0:       return win_lo[w];
      1:       return win_hi[w];
      2:       return win_lo[w] - 32'd1;
      3:       return win_hi[w] + 32'd1;
      default: return win_lo[w] + $urandom_range(win_hi[w] - win_lo[w]);
    endcase
  endfunction

  // One well-formed packet: usually a clear first, then rising and falling
  // edge pairs, a check just short of the idle timeout and one at or past
  // it, and a few reads, some of them beyond the stored count.
  task automatic run_packet(input int unsigned pulses);
    logic [31:0] width;
    logic [8:0]  index;
    if ($urandom_range(99) < 70) begin
      send_req(REQ_CLEAR, 1'($urandom()), $urandom(), $urandom(), 9'($urandom()));
    end
    repeat (pulses) begin
      us_now += $urandom_range(5000, 1);
      send_req(REQ_EDGE, 1'b1, us_now, ms_now, 9'($urandom()));
      width   = pick_width();
      us_now += width;
      ms_now += $urandom_range(3);
      send_req(REQ_EDGE, 1'b0, us_now, ms_now, 9'($urandom()));
    end
    if (timeout_cfg != 0) begin
      send_req(REQ_CHECK, 1'($urandom()), $urandom(), ms_now + timeout_cfg - 32'd1,
               9'($urandom()));
    end
    send_req(REQ_CHECK, 1'($urandom()), $urandom(),
             ms_now + timeout_cfg + $urandom_range(1), 9'($urandom()));
    ms_now += timeout_cfg + 32'd2;
    repeat ($urandom_range(4, 1)) begin
      if ($urandom_range(9) == 0) begin
        index = 9'($urandom());
      end else begin
        index = 9'($urandom_range(pulses + 2));
      end
      send_req(REQ_READ, 1'($urandom()), $urandom(), $urandom(), index);
    end
  endtask

  // Requests with every field random: odd edges, stray checks, reads and
  // clears in between the packets.
  task automatic run_noise(input int unsigned count);
    repeat (count) begin
      send_req(req_type_e'($urandom_range(3)), 1'($urandom()), $urandom(), $urandom(),
               9'($urandom()));
    end
  endtask

  task automatic run_phase(input int unsigned budget);
    int unsigned stop_at;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 75) begin
        run_packet($urandom_range(10, 1));
      end else begin
        run_noise($urandom_range(4, 1));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_wdata    <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    send_idle_pct = 17;
    recv_idle_pct = 57;
    hold_wanted   = 1'b0;
    us_now = $urandom();
    ms_now = $urandom();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. Windows of 10 to 20 and 30 to 40 us, a 5 ms idle
    // timeout and two pulses to a packet.
    configure(32'd10, 32'd20, 32'd30, 32'd40, 32'd5, COUNT_W'(2), 1'b1);
    // Read and check on an empty store.
    send_req(REQ_READ, 1'b0, 32'd0, 32'd0, 9'd0);
    send_req(REQ_CHECK, 1'b1, 32'hFFFF_FFFF, 32'd0, 9'h1FF);
    // The timestamp wraps between rise and fall: 32 us, second window.
    send_req(REQ_EDGE, 1'b1, 32'hFFFF_FFF0, 32'd999, 9'd0);
    send_req(REQ_EDGE, 1'b0, 32'h0000_0010, 32'd1000, 9'd0);
    // 15 us lands in the first window.
    send_req(REQ_EDGE, 1'b1, 32'd100, 32'd1001, 9'd0);
    send_req(REQ_EDGE, 1'b0, 32'd115, 32'd1002, 9'd0);
    // 25 us falls between the windows and is not kept.
    send_req(REQ_EDGE, 1'b1, 32'd200, 32'd1003, 9'd0);
    send_req(REQ_EDGE, 1'b0, 32'd225, 32'd1004, 9'd0);
    // Idle for 4 ms is too short; 5 ms makes the packet ready, and a later
    // check leaves it ready.
    send_req(REQ_CHECK, 1'b0, 32'd0, 32'd1006, 9'd0);
    send_req(REQ_CHECK, 1'b0, 32'd0, 32'd1007, 9'd0);
    send_req(REQ_CHECK, 1'b0, 32'd0, 32'hFFFF_FFFF, 9'd0);
    // An in-window pulse while the packet is pending is measured, not kept.
    send_req(REQ_EDGE, 1'b1, 32'd300, 32'd1008, 9'd0);
    send_req(REQ_EDGE, 1'b0, 32'd318, 32'd1009, 9'd0);
    // Both entries read back; the indexes at and far beyond the count read
    // as zero.
    send_req(REQ_READ, 1'b0, 32'd0, 32'd0, 9'd0);
    send_req(REQ_READ, 1'b0, 32'd0, 32'd0, 9'd1);
    send_req(REQ_READ, 1'b0, 32'd0, 32'd0, 9'd2);
    send_req(REQ_READ, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'h1FF);
    send_req(REQ_CLEAR, 1'b0, 32'd0, 32'd0, 9'd0);
    send_req(REQ_READ, 1'b0, 32'd0, 32'd0, 9'd0);
    // With capture off both edges are ignored and the rise time of 300 us
    // survives, so the falling edge after re-enabling measures 17 us.
    configure(32'd10, 32'd20, 32'd30, 32'd40, 32'd5, COUNT_W'(2), 1'b0);
    send_req(REQ_EDGE, 1'b1, 32'd5, 32'd1010, 9'd0);
    send_req(REQ_EDGE, 1'b0, 32'd317, 32'd1011, 9'd0);
    configure(32'd10, 32'd20, 32'd30, 32'd40, 32'd5, COUNT_W'(2), 1'b1);
    send_req(REQ_EDGE, 1'b0, 32'd317, 32'd1012, 9'd0);
    // Both windows empty, and a minimum count the store can never reach.
    configure(32'd50, 32'd40, 32'hFFFF_FFFF, 32'd0, 32'd0, COUNT_W'(513), 1'b1);
    send_req(REQ_EDGE, 1'b0, 32'd345, 32'd1013, 9'd0);
    send_req(REQ_CHECK, 1'b0, 32'd0, 32'd1013, 9'd0);

    // First random phase: the sender idles a little, the receiver a lot.
    // Narrow random windows, a short timeout and small packets.
    begin : phase_one
      logic [31:0] one_min;
      logic [31:0] zero_min;
      one_min  = $urandom_range(400);
      zero_min = $urandom_range(3000, 1000);
      configure(one_min, one_min + $urandom_range(400), zero_min,
                zero_min + $urandom_range(800), $urandom_range(30, 1),
                COUNT_W'($urandom_range(8, 1)), 1'b1);
    end
    run_phase(PHASE_ITEMS);

    // Second phase: idling swapped. The first window takes every width,
    // the timeout is at its maximum and no minimum count applies.
    send_idle_pct = 57;
    recv_idle_pct = 17;
    configure(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd65535,
              COUNT_W'(0), 1'b1);
    run_phase(PHASE_ITEMS);

    // Third phase: no idling, except for one long receiver hold-off at the
    // start. One rise, then more in-window falls than the store holds, so
    // the last of them are dropped. A full store then makes a packet.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(32'd100, 32'd200, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'd0,
              COUNT_W'(STORE_DEPTH), 1'b1);
    hold_wanted = 1'b1;
    send_req(REQ_CLEAR, 1'b0, 32'd0, ms_now, 9'd0);
    send_req(REQ_EDGE, 1'b1, us_now, ms_now, 9'($urandom()));
    repeat (FILL_EDGES) begin
      ms_now += 32'd1;
      send_req(REQ_EDGE, 1'b0, us_now + $urandom_range(200, 100), ms_now, 9'($urandom()));
    end
    send_req(REQ_CHECK, 1'b0, 32'd0, ms_now, 9'd0);
    send_req(REQ_READ, 1'b0, 32'd0, 32'd0, 9'h1FF);
    send_req(REQ_READ, 1'b0, 32'd0, 32'd0, 9'd0);
    run_phase(60);

    settle();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pwcb_pkg.sv
rtl/pwcb_if.sv
rtl/pwcb_ram.sv
rtl/pulse_width_capture_buffer_core.sv
sim/pwcb_response_checker.sv
sim/pulse_width_capture_buffer_core_test.sv
